// ===== rtl/matrix_multiply_fixed_assert.svh =====
// assertion macros shared by the matrix multiply rtl
`ifndef MATRIX_MULTIPLY_FIXED_ASSERT_SVH
`define MATRIX_MULTIPLY_FIXED_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define MMF_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("matrix multiply check failed");

// consequent must hold in the cycle after the antecedent
`define MMF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("matrix multiply check failed");

`endif

// ===== rtl/mmf_pkg.sv =====
// shared types, constants and helpers for the fixed-point matrix multiply
package mmf_pkg;

    localparam int MAX_DIM   = 8;
    localparam int ELEM_BITS = 16;

    localparam int DEPTH   = MAX_DIM * MAX_DIM;
    localparam int IDX_W   = $clog2(DEPTH);
    localparam int DIM_W   = $clog2(MAX_DIM);
    localparam int CNT_W   = $clog2(MAX_DIM + 1);
    localparam int PROD_W  = 2 * ELEM_BITS;

    // fixed field widths of the channels
    localparam int OP_W       = 2;
    localparam int INDEX_W    = 6;
    localparam int VALUE_W    = 16;
    localparam int ACC_W      = 34;
    localparam int POS_W      = 3;
    localparam int CFG_W      = 4;
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    typedef enum logic [OP_W-1:0] {
        OP_WRITE_A = 2'd0,
        OP_WRITE_B = 2'd1,
        OP_COMPUTE = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        REG_ROWS_A    = 2'd0,
        REG_INNER_DIM = 2'd1,
        REG_COLS_B    = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic [CNT_W-1:0] ra;
        logic [CNT_W-1:0] nk;
        logic [CNT_W-1:0] cb;
    } dims_t;

    // flags that ride with each multiply-accumulate beat
    typedef struct packed {
        logic             first;
        logic             lastk;
        logic             zero;
        logic             last;
        logic [DIM_W-1:0] row;
        logic [DIM_W-1:0] col;
    } tag_t;

    typedef struct packed {
        logic                        en_a;
        logic                        en_b;
        logic [IDX_W-1:0]            idx;
        logic signed [ELEM_BITS-1:0] data;
    } wr_req_t;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] a_idx;
        logic [IDX_W-1:0] b_idx;
        tag_t             tag;
    } rd_req_t;

    typedef struct packed {
        logic                        valid;
        logic signed [ELEM_BITS-1:0] a;
        logic signed [ELEM_BITS-1:0] b;
        tag_t                        tag;
    } rd_rsp_t;

    typedef struct packed {
        logic pipe_busy;
        logic out_free;
    } mac_status_t;

    function automatic logic [CNT_W-1:0] clamp_dim(input logic [CFG_W-1:0] d);
        logic [CNT_W-1:0] r;
        if (d > CFG_W'(MAX_DIM))
            r = CNT_W'(MAX_DIM);
        else
            r = CNT_W'(d);
        return r;
    endfunction

endpackage

// ===== rtl/mmf_if.sv =====
// valid/ready channel interfaces for command and result beats
interface mmf_cmd_if;
    import mmf_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [OP_W-1:0]           op;
    logic [INDEX_W-1:0]        elem_index;
    logic signed [VALUE_W-1:0] elem_value;

    modport source (output valid, output op, output elem_index, output elem_value,
                    input ready);
    modport sink (input valid, input op, input elem_index, input elem_value,
                  output ready);
endinterface

interface mmf_res_if;
    import mmf_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [ACC_W-1:0] prod_value;
    logic [POS_W-1:0]        prod_row;
    logic [POS_W-1:0]        prod_col;
    logic                    last;

    modport source (output valid, output prod_value, output prod_row, output prod_col,
                    output last, input ready);
    modport sink (input valid, input prod_value, input prod_row, input prod_col,
                  input last, output ready);
endinterface

// ===== rtl/mmf_store.sv =====
// element memories for matrices a and b with registered read port
module mmf_store (
    input  logic             clk,
    input  logic             rst_n,
    input  mmf_pkg::wr_req_t wr,
    input  mmf_pkg::rd_req_t rd,
    output mmf_pkg::rd_rsp_t rsp
);
    import mmf_pkg::*;

    logic signed [ELEM_BITS-1:0] mem_a [DEPTH];
    logic signed [ELEM_BITS-1:0] mem_b [DEPTH];

    logic                        valid_reg;
    logic signed [ELEM_BITS-1:0] a_reg;
    logic signed [ELEM_BITS-1:0] b_reg;
    tag_t                        tag_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en_a)
        begin
            mem_a[wr.idx] <= wr.data;
        end
        if (wr.en_b)
        begin
            mem_b[wr.idx] <= wr.data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd.en)
        begin
            a_reg   <= mem_a[rd.a_idx];
            b_reg   <= mem_b[rd.b_idx];
            tag_reg <= rd.tag;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= rd.en;
        end
    end

    assign rsp.valid = valid_reg;
    assign rsp.a     = a_reg;
    assign rsp.b     = b_reg;
    assign rsp.tag   = tag_reg;

endmodule

// ===== rtl/mmf_mac.sv =====
// shared multiplier, accumulator and result register
module mmf_mac (
    input  logic                  clk,
    input  logic                  rst_n,
    input  mmf_pkg::rd_rsp_t      rsp,
    output mmf_pkg::mac_status_t  status,
    mmf_res_if.source             res
);
    import mmf_pkg::*;

    logic                     s2_valid_reg;
    logic signed [PROD_W-1:0] prod_reg;
    tag_t                     s2_tag_reg;

    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;

    logic                     out_valid_reg;
    logic signed [ACC_W-1:0]  out_value_reg;
    logic [POS_W-1:0]         out_row_reg;
    logic [POS_W-1:0]         out_col_reg;
    logic                     out_last_reg;
    logic                     out_fire;
    logic                     out_load;

    assign out_fire = out_valid_reg && res.ready;
    assign out_load = s2_valid_reg && s2_tag_reg.lastk;

    // an empty inner dimension sends one beat whose product is forced to zero
    always_ff @(posedge clk)
    begin
        if (rsp.valid)
        begin
            if (rsp.tag.zero)
            begin
                prod_reg <= '0;
            end
            else
            begin
                prod_reg <= rsp.a * rsp.b;
            end
            s2_tag_reg <= rsp.tag;
        end
    end

    always_comb
    begin
        acc_next = (s2_tag_reg.first ? '0 : acc_reg) + ACC_W'(prod_reg);
    end

    always_ff @(posedge clk)
    begin
        if (s2_valid_reg)
        begin
            acc_reg <= acc_next;
        end
        if (out_load)
        begin
            out_value_reg <= acc_next;
            out_row_reg   <= POS_W'(s2_tag_reg.row);
            out_col_reg   <= POS_W'(s2_tag_reg.col);
            out_last_reg  <= s2_tag_reg.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg <= rsp.valid;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_fire)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign status.pipe_busy = rsp.valid || s2_valid_reg;
    assign status.out_free  = !out_valid_reg || res.ready;

    assign res.valid      = out_valid_reg;
    assign res.prod_value = out_value_reg;
    assign res.prod_row   = out_row_reg;
    assign res.prod_col   = out_col_reg;
    assign res.last       = out_last_reg;

`include "matrix_multiply_fixed_assert.svh"

    // a finished sum never lands on a beat still waiting at the output
    `MMF_ASSERT_SAME(a_no_overrun, out_load, !out_valid_reg || res.ready)
    // the forced-zero beat is the only beat of its element
    `MMF_ASSERT_SAME(a_zero_single, s2_valid_reg && s2_tag_reg.zero,
                     s2_tag_reg.first && s2_tag_reg.lastk)

endmodule

// ===== rtl/mmf_seq.sv =====
// command decode and i/j/k sequencer feeding the shared mac
module mmf_seq (
    input  logic                 clk,
    input  logic                 rst_n,
    input  mmf_pkg::dims_t       dims,
    input  mmf_pkg::mac_status_t mac_st,
    mmf_cmd_if.sink              cmd,
    output mmf_pkg::wr_req_t     wr,
    output mmf_pkg::rd_req_t     rd
);
    import mmf_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_SYNC  = 3'b010,
        ST_ISSUE = 3'b100
    } state_t;

    state_t           state_reg, state_next;
    logic [DIM_W-1:0] i_reg, i_next;
    logic [DIM_W-1:0] j_reg, j_next;
    logic [DIM_W-1:0] k_reg, k_next;
    logic [IDX_W-1:0] a_base_reg, a_base_next;
    logic [IDX_W-1:0] a_idx_reg, a_idx_next;
    logic [IDX_W-1:0] b_idx_reg, b_idx_next;

    op_t  op_code;
    logic cmd_fire;
    logic idx_ok;
    logic dims_nonzero;
    logic last_k, last_j, last_i;

    assign op_code      = op_t'(cmd.op);
    assign cmd.ready    = (state_reg == ST_IDLE);
    assign cmd_fire     = cmd.valid && cmd.ready;
    assign idx_ok       = ({1'b0, cmd.elem_index} < (INDEX_W + 1)'(DEPTH));
    assign dims_nonzero = (dims.ra != '0) && (dims.cb != '0);

    assign last_k = (dims.nk == '0) || ((CNT_W'(k_reg) + CNT_W'(1)) == dims.nk);
    assign last_j = (CNT_W'(j_reg) + CNT_W'(1)) == dims.cb;
    assign last_i = (CNT_W'(i_reg) + CNT_W'(1)) == dims.ra;

    // store writes happen on the accepting edge
    always_comb
    begin
        wr.en_a = 1'b0;
        wr.en_b = 1'b0;
        wr.idx  = cmd.elem_index[IDX_W-1:0];
        wr.data = ELEM_BITS'(32'(cmd.elem_value));
        if (cmd_fire && idx_ok)
        begin
            case (op_code)
                OP_WRITE_A: wr.en_a = 1'b1;
                OP_WRITE_B: wr.en_b = 1'b1;
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        rd.en        = (state_reg == ST_ISSUE);
        rd.a_idx     = a_idx_reg;
        rd.b_idx     = b_idx_reg;
        rd.tag.first = (k_reg == '0);
        rd.tag.lastk = last_k;
        rd.tag.zero  = (dims.nk == '0);
        rd.tag.last  = last_i && last_j;
        rd.tag.row   = i_reg;
        rd.tag.col   = j_reg;
    end

    always_comb
    begin
        state_next  = state_reg;
        i_next      = i_reg;
        j_next      = j_reg;
        k_next      = k_reg;
        a_base_next = a_base_reg;
        a_idx_next  = a_idx_reg;
        b_idx_next  = b_idx_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_fire && (op_code == OP_COMPUTE) && dims_nonzero)
                begin
                    state_next  = ST_SYNC;
                    i_next      = '0;
                    j_next      = '0;
                    k_next      = '0;
                    a_base_next = '0;
                    a_idx_next  = '0;
                    b_idx_next  = '0;
                end
            end
            ST_SYNC:
            begin
                // start an element only once the mac is drained and the output is free
                if (!mac_st.pipe_busy && mac_st.out_free)
                begin
                    state_next = ST_ISSUE;
                end
            end
            ST_ISSUE:
            begin
                if (!last_k)
                begin
                    k_next     = k_reg + DIM_W'(1);
                    a_idx_next = a_idx_reg + IDX_W'(1);
                    b_idx_next = b_idx_reg + IDX_W'(dims.cb);
                end
                else
                begin
                    k_next = '0;
                    if (last_j)
                    begin
                        j_next      = '0;
                        i_next      = i_reg + DIM_W'(1);
                        a_base_next = a_base_reg + IDX_W'(dims.nk);
                        a_idx_next  = a_base_reg + IDX_W'(dims.nk);
                        b_idx_next  = '0;
                        state_next  = last_i ? ST_IDLE : ST_SYNC;
                    end
                    else
                    begin
                        j_next     = j_reg + DIM_W'(1);
                        a_idx_next = a_base_reg;
                        b_idx_next = IDX_W'(j_reg) + IDX_W'(1);
                        state_next = ST_SYNC;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg      <= i_next;
        j_reg      <= j_next;
        k_reg      <= k_next;
        a_base_reg <= a_base_next;
        a_idx_reg  <= a_idx_next;
        b_idx_reg  <= b_idx_next;
    end

`include "matrix_multiply_fixed_assert.svh"

    `MMF_ASSERT_NEXT(a_compute_starts,
                     cmd_fire && (op_code == OP_COMPUTE) && dims_nonzero,
                     state_reg == ST_SYNC)
    `MMF_ASSERT_NEXT(a_run_ends_idle,
                     (state_reg == ST_ISSUE) && last_k && last_i && last_j,
                     state_reg == ST_IDLE)

endmodule

// ===== rtl/matrix_multiply_fixed.sv =====
// top level of the fixed-point matrix multiply with its configuration registers
//
// Usage: matrices A (rows_a x inner_dim) and B (inner_dim x cols_b) are loaded one
// element per command beat on cmd (op 0 writes A, op 1 writes B, at a row-major
// elem_index, signed Q4.12 elem_value). A compute beat (op 2) streams the product
// on res in row-major order, one beat per element with its row, column and a
// signed Q10.24 prod_value; last marks the final element. Each element runs
// max(inner_dim,1) multiply-accumulate steps on the single shared multiplier,
// each passing through the memory read, multiply and accumulate registers.
// cmd.ready is low for the whole run; the next element does not start until the
// output register is free, so a stalled receiver holds the run without loss.
// Dimensions are set through the APB port (rows_a at 0x0, inner_dim at 0x4,
// cols_b at 0x8, all reset to 8, values above 8 act as 8); the user must change
// them only while idle, and the block itself does not enforce this. Reset clears
// the control state and sets the dimension registers to 8; the element stores
// are not cleared and must be written before use.
module matrix_multiply_fixed (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [mmf_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [mmf_pkg::APB_DATA_W-1:0] pwdata,
    output logic [mmf_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready,
    mmf_cmd_if.sink                        cmd,
    mmf_res_if.source                      res
);
    import mmf_pkg::*;

    logic [CFG_W-1:0] rows_a_reg;
    logic [CFG_W-1:0] inner_dim_reg;
    logic [CFG_W-1:0] cols_b_reg;

    reg_idx_t    reg_sel;
    logic        apb_write;
    dims_t       dims;
    mac_status_t mac_st;
    wr_req_t     wr;
    rd_req_t     rd;
    rd_rsp_t     rsp;

    assign pready    = 1'b1;
    assign reg_sel   = reg_idx_t'(paddr[3:2]);
    assign apb_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_a_reg    <= CFG_W'(MAX_DIM);
            inner_dim_reg <= CFG_W'(MAX_DIM);
            cols_b_reg    <= CFG_W'(MAX_DIM);
        end
        else if (apb_write)
        begin
            case (reg_sel)
                REG_ROWS_A:    rows_a_reg    <= pwdata[CFG_W-1:0];
                REG_INNER_DIM: inner_dim_reg <= pwdata[CFG_W-1:0];
                REG_COLS_B:    cols_b_reg    <= pwdata[CFG_W-1:0];
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            REG_ROWS_A:    prdata = APB_DATA_W'(rows_a_reg);
            REG_INNER_DIM: prdata = APB_DATA_W'(inner_dim_reg);
            REG_COLS_B:    prdata = APB_DATA_W'(cols_b_reg);
            default:       prdata = '0;
        endcase
    end

    assign dims.ra = clamp_dim(rows_a_reg);
    assign dims.nk = clamp_dim(inner_dim_reg);
    assign dims.cb = clamp_dim(cols_b_reg);

    mmf_seq u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .dims   (dims),
        .mac_st (mac_st),
        .cmd    (cmd),
        .wr     (wr),
        .rd     (rd)
    );

    mmf_store u_store (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (wr),
        .rd    (rd),
        .rsp   (rsp)
    );

    mmf_mac u_mac (
        .clk    (clk),
        .rst_n  (rst_n),
        .rsp    (rsp),
        .status (mac_st),
        .res    (res)
    );

endmodule

// ===== sim/matrix_multiply_fixed_test.sv =====
// self-checking testbench for the fixed-point matrix multiply
module matrix_multiply_fixed_test;
    timeunit 1ns;
    timeprecision 1ps;

    import mmf_pkg::*;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS   = 450;
    localparam int SETTLE_CYCLES  = 40;
    localparam int HOLDOFF_CYCLES = 300;
    localparam int WATCHDOG_LIMIT = 3000;

    typedef struct packed {
        logic [OP_W-1:0]           op;
        logic [INDEX_W-1:0]        idx;
        logic signed [VALUE_W-1:0] value;
    } cmd_item_t;

    typedef struct packed {
        logic signed [ACC_W-1:0] value;
        logic [POS_W-1:0]        row;
        logic [POS_W-1:0]        col;
        logic                    last;
    } product_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    mmf_cmd_if cmd_ch ();
    mmf_res_if res_ch ();

    matrix_multiply_fixed u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cmd     (cmd_ch),
        .res     (res_ch)
    );

    // predictor state
    logic signed [VALUE_W-1:0] mat_a [DEPTH];
    logic signed [VALUE_W-1:0] mat_b [DEPTH];
    logic [CFG_W-1:0]          dim_rows  = CFG_W'(MAX_DIM);
    logic [CFG_W-1:0]          dim_inner = CFG_W'(MAX_DIM);
    logic [CFG_W-1:0]          dim_cols  = CFG_W'(MAX_DIM);
    product_t                  pending_products [$];

    // stimulus side bookkeeping
    cmd_item_t cmd_q [$];
    bit        a_loaded [DEPTH];
    bit        b_loaded [DEPTH];
    int        gen_rows;
    int        gen_inner;
    int        gen_cols;
    int        queued_cnt   = 0;
    int        accepted_cnt = 0;
    int        stim_count   = 0;
    int        fail_count   = 0;
    int        send_idle_pct  = 0;
    int        recv_stall_pct = 0;
    logic      cmd_taken      = 1'b0;
    logic      holdoff_req;
    int        holdoff_left   = 0;
    int        idle_cycles    = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int dim_limit(input logic [CFG_W-1:0] d);
        return (d > CFG_W'(MAX_DIM)) ? MAX_DIM : int'(d);
    endfunction

    // update the element stores, or work out the whole product for a compute beat
    task automatic apply_command(input logic [OP_W-1:0] op, input logic [INDEX_W-1:0] idx,
                                 input logic signed [VALUE_W-1:0] val);
        int       nr;
        int       nk;
        int       nc;
        longint   sum;
        product_t p;
        case (op)
            OP_WRITE_A: mat_a[idx] = val;
            OP_WRITE_B: mat_b[idx] = val;
            OP_COMPUTE:
            begin
                nr = dim_limit(dim_rows);
                nk = dim_limit(dim_inner);
                nc = dim_limit(dim_cols);
                for (int i = 0; i < nr; i++)
                begin
                    for (int j = 0; j < nc; j++)
                    begin
                        sum = 0;
                        for (int k = 0; k < nk; k++)
                            sum += longint'(mat_a[i * nk + k]) * longint'(mat_b[k * nc + j]);
                        p.value = ACC_W'(sum);
                        p.row   = POS_W'(i);
                        p.col   = POS_W'(j);
                        p.last  = (i == nr - 1) && (j == nc - 1);
                        pending_products.push_back(p);
                    end
                end
            end
            default: ;
        endcase
    endtask

    function automatic void check_field(input string name, input logic signed [ACC_W-1:0] want,
                                        input logic signed [ACC_W-1:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endfunction

    // monitor: predictor updates and result checks
    always @(posedge clk)
    begin : monitor
        product_t want;
        cmd_taken <= cmd_ch.valid && cmd_ch.ready;
        if (psel && penable && pwrite && pready)
        begin
            case (paddr[APB_ADDR_W-1:2])
                REG_ROWS_A:    dim_rows  = pwdata[CFG_W-1:0];
                REG_INNER_DIM: dim_inner = pwdata[CFG_W-1:0];
                REG_COLS_B:    dim_cols  = pwdata[CFG_W-1:0];
                default: ;
            endcase
        end
        if (cmd_ch.valid && cmd_ch.ready)
        begin
            accepted_cnt++;
            apply_command(cmd_ch.op, cmd_ch.elem_index, cmd_ch.elem_value);
        end
        if (res_ch.valid && res_ch.ready)
        begin
            if (pending_products.size() == 0)
            begin
                $error("unexpected product beat: row %0d col %0d value %0d",
                       res_ch.prod_row, res_ch.prod_col, res_ch.prod_value);
                fail_count++;
            end
            else
            begin
                want = pending_products.pop_front();
                check_field("prod_value", want.value, res_ch.prod_value);
                check_field("prod_row", want.row, res_ch.prod_row);
                check_field("prod_col", want.col, res_ch.prod_col);
                check_field("last", want.last, res_ch.last);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready) ||
            (psel && penable && pwrite && pready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles == WATCHDOG_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // command driver
    always @(negedge clk)
    begin : driver
        cmd_item_t item;
        if (!cmd_ch.valid || cmd_taken)
        begin
            if (cmd_q.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                item = cmd_q.pop_front();
                cmd_ch.valid      <= 1'b1;
                cmd_ch.op         <= item.op;
                cmd_ch.elem_index <= item.idx;
                cmd_ch.elem_value <= item.value;
            end
            else
                cmd_ch.valid <= 1'b0;
        end
    end

    always @(negedge clk)
    begin
        if (holdoff_left != 0)
            holdoff_left <= holdoff_left - 1;
        else if (holdoff_req)
            holdoff_left <= HOLDOFF_CYCLES;
    end

    always @(negedge clk)
        res_ch.ready <= !holdoff_req && holdoff_left == 0 &&
                        $urandom_range(99) >= recv_stall_pct;

    function automatic void push_cmd(input logic [OP_W-1:0] op, input int idx,
                                     input logic signed [VALUE_W-1:0] val);
        cmd_item_t item;
        item.op    = op;
        item.idx   = INDEX_W'(idx);
        item.value = val;
        cmd_q.push_back(item);
        queued_cnt++;
        if (op == OP_WRITE_A)
            a_loaded[idx] = 1'b1;
        if (op == OP_WRITE_B)
            b_loaded[idx] = 1'b1;
        if (op != OP_UNUSED)
            stim_count++;
    endfunction

    function automatic logic signed [VALUE_W-1:0] pick_value();
        case ($urandom_range(9))
            0:       return 16'sh8000;
            1:       return 16'sh7fff;
            default: return VALUE_W'($urandom);
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] pick_dim();
        case ($urandom_range(19))
            0:       return '0;
            1:       return CFG_W'($urandom_range(9, 15));
            2, 3:    return CFG_W'($urandom_range(5, 8));
            default: return CFG_W'($urandom_range(1, 4));
        endcase
    endfunction

    // fresh elements, any element still unwritten, then one or two compute beats
    task automatic queue_product_run();
        int a_cnt;
        int b_cnt;
        a_cnt = gen_rows * gen_inner;
        b_cnt = gen_inner * gen_cols;
        if (a_cnt + b_cnt > 0)
        begin
            repeat ($urandom_range(0, (a_cnt + b_cnt) / 2))
            begin
                if (b_cnt == 0 || (a_cnt > 0 && $urandom_range(1) == 0))
                    push_cmd(OP_WRITE_A, $urandom_range(0, a_cnt - 1), pick_value());
                else
                    push_cmd(OP_WRITE_B, $urandom_range(0, b_cnt - 1), pick_value());
            end
        end
        if ($urandom_range(7) == 0)
            push_cmd(OP_UNUSED, $urandom_range(63), pick_value());
        if ($urandom_range(7) == 0)
            push_cmd($urandom_range(1) ? OP_WRITE_A : OP_WRITE_B, $urandom_range(63),
                     pick_value());
        for (int n = 0; n < DEPTH; n++)
        begin
            if (n < a_cnt && !a_loaded[n])
                push_cmd(OP_WRITE_A, n, pick_value());
            if (n < b_cnt && !b_loaded[n])
                push_cmd(OP_WRITE_B, n, pick_value());
        end
        push_cmd(OP_COMPUTE, $urandom_range(63), pick_value());
        if ($urandom_range(9) == 0)
            push_cmd(OP_COMPUTE, $urandom_range(63), pick_value());
    endtask

    task automatic wait_for_products();
        do
            @(negedge clk);
        while (accepted_cnt != queued_cnt || pending_products.size() != 0);
    endtask

    task automatic write_reg(input reg_idx_t r, input logic [CFG_W-1:0] v);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_W'({r, 2'b00});
        pwdata  <= APB_DATA_W'(v);
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // dimensions change only once the block has drained and gone quiet
    task automatic configure(input logic [CFG_W-1:0] r, input logic [CFG_W-1:0] k,
                             input logic [CFG_W-1:0] c);
        wait_for_products();
        repeat (SETTLE_CYCLES) @(negedge clk);
        write_reg(REG_ROWS_A, r);
        write_reg(REG_INNER_DIM, k);
        write_reg(REG_COLS_B, c);
        gen_rows  = dim_limit(r);
        gen_inner = dim_limit(k);
        gen_cols  = dim_limit(c);
        @(posedge clk);
    endtask

    initial
    begin : stimulus
        int phase;
        int runs;
        for (int n = 0; n < DEPTH; n++)
        begin
            mat_a[n] = '0;
            mat_b[n] = '0;
        end
        rst_n             = 1'b0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;
        holdoff_req       = 1'b0;
        cmd_ch.valid      = 1'b0;
        cmd_ch.op         = '0;
        cmd_ch.elem_index = '0;
        cmd_ch.elem_value = '0;
        res_ch.ready      = 1'b0;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;

        // single element products at the operand extremes, plus an unused op
        configure(1, 1, 1);
        push_cmd(OP_WRITE_A, 0, 16'sh8000);
        push_cmd(OP_WRITE_B, 0, 16'sh8000);
        push_cmd(OP_COMPUTE, 0, '0);
        push_cmd(OP_WRITE_A, 0, 16'sh7fff);
        push_cmd(OP_UNUSED, 63, -1);
        push_cmd(OP_COMPUTE, 63, -1);

        // longest dot product of most negative operands wraps the sum
        configure(1, 8, 1);
        for (int k = 0; k < MAX_DIM; k++)
        begin
            push_cmd(OP_WRITE_A, k, 16'sh8000);
            push_cmd(OP_WRITE_B, k, 16'sh8000);
        end
        push_cmd(OP_COMPUTE, 0, '0);

        // empty products and the empty sum
        configure(0, 3, 2);
        push_cmd(OP_COMPUTE, 0, '0);
        configure(2, 0, 2);
        push_cmd(OP_COMPUTE, 0, '0);
        configure(3, 2, 0);
        push_cmd(OP_COMPUTE, 0, '0);

        stim_count = 0;
        phase      = 0;
        while (stim_count < RANDOM_ITEMS)
        begin
            case (phase)
                0:       configure(3, 4, 3);
                1:       configure(9, 2, 15);
                2:       configure(12, 8, 8);
                default: configure(pick_dim(), pick_dim(), pick_dim());
            endcase
            case (phase % 5)
                1:
                begin
                    send_idle_pct  = 78;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 78;
                end
                3:
                begin
                    send_idle_pct  = 14;
                    recv_stall_pct = 14;
                end
                default:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
            endcase
            // long receiver hold-off while several runs are queued behind it
            if (phase == 0)
            begin
                holdoff_req = 1'b1;
                while (holdoff_left == 0)
                    @(posedge clk);
                holdoff_req = 1'b0;
            end
            runs = (phase == 2) ? 1 : $urandom_range(2, 4);
            repeat (runs) queue_product_run();
            phase++;
        end

        wait_for_products();
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (pending_products.size() != 0)
        begin
            $error("%0d product beats never arrived", pending_products.size());
            fail_count++;
        end
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
